### sv/gbf_pkg.sv
// Shared types, sizes and codes for the graph bridge finder.
package gbf_pkg;

    localparam int NODE_W = 10;
    localparam int NODES  = 1024;
    localparam int LINK_W = 12;
    localparam int LINKS  = 4096;
    localparam int CNT_W  = 11;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]        op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] bridge_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [NODE_W-1:0] bridge_count;
        logic [NODE_W-1:0] end_low;
        logic [NODE_W-1:0] end_high;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_CLR,
        S_ADD1,
        S_ADD2,
        S_ADD3,
        S_VCLR,
        S_ROOT,
        S_ROOT_RD,
        S_ENTER,
        S_TOP,
        S_TOP_RD,
        S_NB,
        S_NB_RD,
        S_NB_CHK,
        S_POP,
        S_POP_RD,
        S_POP_UPD,
        S_SORT_I,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_PUT,
        S_READ,
        S_READ_RD,
        S_OUT
    } t_state;

endpackage

### sv/gbf_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module gbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/graph_bridge_finder.sv
// Top level of the graph bridge finder: sequencer, datapath and RAMs.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------
//  in      | input     | i_valid / o_stall  | i_in  (t_in_item)
//  out     | output    | o_valid / i_stall  | o_out (t_out_item)
//  cfg     | input     | i_cfg_we           | i_cfg_data (node_count)
//
// After reset a clearing pass over all 1024 head entries empties the head
// store; no item is taken meanwhile. Add edge writes two adjacency entries
// and two heads, or reports full when the store is full; clear graph sweeps
// the head store; read looks up one stored bridge. A run clears the visit
// marks, scans the roots, enters nodes, walks their adjacency entries and
// pops frames on a stack, then sorts the bridges, with at most k*(k-1)/2
// shifts for k bridges. One item is in work at a time; the result sits in
// the output register until taken, and the next item is taken at that edge
// at the earliest.
module graph_bridge_finder
    import gbf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  t_in_item        i_in,
    output logic            o_valid,
    input  logic            i_stall,
    output t_out_item       o_out,
    input  logic            i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data
);
    // Head entries carry a valid bit; invalid marks an empty list.
    localparam int HEAD_W = LINK_W + 1;
    // Stack frame: node, parent, has_parent, link valid, link.
    localparam int FRM_W  = NODE_W + NODE_W + 1 + HEAD_W;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_node_count;
    t_in_item          r_item;
    t_out_item         r_out, n_out;
    logic              r_ovalid;
    logic [LINK_W:0]   r_used;
    logic [NODE_W:0]   r_cnt;          // clearing sweep / root index
    logic [NODE_W:0]   r_depth;        // stack depth
    logic [NODE_W-1:0] r_clock;
    logic [NODE_W:0]   r_found;        // bridges of this run
    logic [NODE_W-1:0] r_count;        // reported bridge count

    // current frame
    logic [NODE_W-1:0] r_fn, r_fp;
    logic              r_fhp;
    logic [HEAD_W-1:0] r_flink;
    logic [NODE_W-1:0] r_child;
    logic [NODE_W-1:0] r_lown;         // low of current node
    logic [NODE_W-1:0] r_discn;        // discovery of current node
    logic [NODE_W-1:0] r_popn;         // popped child
    // sort
    logic [NODE_W:0]   r_si, r_sj;
    logic [2*NODE_W-1:0] r_key;

    // ---------------- memories ----------------
    logic              head_we;
    logic [NODE_W-1:0] head_wa, head_ra;
    logic [HEAD_W-1:0] head_wd, head_rd;
    gbf_ram #(.WIDTH(HEAD_W), .DEPTH(NODES)) u_head (
        .i_clk, .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(head_ra), .o_rdata(head_rd));

    logic              adj_we;
    logic [LINK_W-1:0] adj_wa, adj_ra;
    logic [HEAD_W+NODE_W-1:0] adj_wd, adj_rd;
    gbf_ram #(.WIDTH(HEAD_W+NODE_W), .DEPTH(LINKS)) u_adj (
        .i_clk, .i_we(adj_we), .i_waddr(adj_wa), .i_wdata(adj_wd),
        .i_raddr(adj_ra), .o_rdata(adj_rd));

    // node info: visited, discovery, low
    localparam int INFO_W = 1 + 2*NODE_W;
    logic              inf_we;
    logic [NODE_W-1:0] inf_wa, inf_ra;
    logic [INFO_W-1:0] inf_wd, inf_rd;
    gbf_ram #(.WIDTH(INFO_W), .DEPTH(NODES)) u_info (
        .i_clk, .i_we(inf_we), .i_waddr(inf_wa), .i_wdata(inf_wd),
        .i_raddr(inf_ra), .o_rdata(inf_rd));

    logic              stk_we;
    logic [NODE_W-1:0] stk_wa, stk_ra;
    logic [FRM_W-1:0]  stk_wd, stk_rd;
    gbf_ram #(.WIDTH(FRM_W), .DEPTH(NODES)) u_stack (
        .i_clk, .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd));

    logic                br_we;
    logic [NODE_W-1:0]   br_wa, br_ra;
    logic [2*NODE_W-1:0] br_wd, br_rd;
    gbf_ram #(.WIDTH(2*NODE_W), .DEPTH(NODES)) u_bridge (
        .i_clk, .i_we(br_we), .i_waddr(br_wa), .i_wdata(br_wd),
        .i_raddr(br_ra), .o_rdata(br_rd));

    // field views
    logic              inf_vis;
    logic [NODE_W-1:0] inf_disc, inf_low;
    assign inf_vis  = inf_rd[INFO_W-1];
    assign inf_disc = inf_rd[2*NODE_W-1:NODE_W];
    assign inf_low  = inf_rd[NODE_W-1:0];

    logic [HEAD_W-1:0] adj_next;
    logic [NODE_W-1:0] adj_nb;
    assign adj_next = adj_rd[HEAD_W+NODE_W-1:NODE_W];
    assign adj_nb   = adj_rd[NODE_W-1:0];

    logic [NODE_W:0] limit;
    assign limit = (r_node_count > CNT_W'(NODES)) ? (NODE_W+1)'(NODES)
                                                  : r_node_count[NODE_W:0];

    logic [NODE_W-1:0] top_idx;
    assign top_idx = NODE_W'(r_depth - 1'b1);

    // neighbour is the parent of the current node: skip it
    logic nb_skip;
    assign nb_skip = r_fhp && (r_child == r_fp);

    // Shift step of the insertion sort: move entries up while larger than key.
    logic sort_move;
    assign sort_move = (r_sj != '0) && (br_rd > r_key);

    logic take;
    assign take    = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (t_op'(i_in.op))
                        OP_ADD:   n_state = S_ADD1;
                        OP_RUN:   n_state = S_VCLR;
                        OP_READ:  n_state = S_READ;
                        default:  n_state = S_CLR;
                    endcase
                end
            end
            S_INIT:  if (r_cnt == (NODE_W+1)'(NODES-1)) n_state = S_IDLE;
            S_CLR:   if (r_cnt == (NODE_W+1)'(NODES-1)) n_state = S_OUT;
            S_ADD1:  n_state = (r_used > (LINK_W+1)'(LINKS-2)) ? S_OUT : S_ADD2;
            S_ADD2:  n_state = S_ADD3;
            S_ADD3:  n_state = S_OUT;
            S_VCLR:  if (r_cnt == (NODE_W+1)'(NODES-1)) n_state = S_ROOT;
            S_ROOT:  n_state = (r_cnt >= limit) ? S_SORT_I : S_ROOT_RD;
            S_ROOT_RD: n_state = inf_vis ? S_ROOT : S_ENTER;
            S_ENTER: n_state = S_TOP;
            S_TOP:   n_state = (r_depth == '0) ? S_ROOT : S_TOP_RD;
            S_TOP_RD: n_state = S_NB;
            S_NB:    n_state = r_flink[HEAD_W-1] ? S_NB_RD : S_POP;
            S_NB_RD: n_state = S_NB_CHK;
            S_NB_CHK: begin
                n_state = S_TOP;
                if (!nb_skip && !inf_vis && r_depth < (NODE_W+1)'(NODES))
                    n_state = S_ENTER;
            end
            S_POP:   n_state = (r_depth == (NODE_W+1)'(1)) ? S_TOP : S_POP_RD;
            S_POP_RD: n_state = S_POP_UPD;
            S_POP_UPD: n_state = S_TOP;
            S_SORT_I: n_state = (r_si >= r_found) ? S_OUT : S_SORT_RD;
            S_SORT_RD: n_state = S_SORT_CMP;
            S_SORT_CMP: n_state = sort_move ? S_SORT_CMP : S_SORT_PUT;
            S_SORT_PUT: n_state = S_SORT_I;
            S_READ:  n_state = S_READ_RD;
            S_READ_RD: n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- memory control and result ----------------
    always_comb begin
        head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
        adj_we = 1'b0;  adj_wa = '0;  adj_wd = '0;  adj_ra = r_flink[LINK_W-1:0];
        inf_we = 1'b0;  inf_wa = '0;  inf_wd = '0;  inf_ra = '0;
        stk_we = 1'b0;  stk_wa = '0;  stk_wd = '0;  stk_ra = top_idx;
        br_we = 1'b0;   br_wa = '0;   br_wd = '0;   br_ra = '0;
        n_out = r_out;
        case (r_state)
            S_CLR, S_INIT: begin
                head_we = 1'b1; head_wa = r_cnt[NODE_W-1:0];
            end
            S_ADD1: begin
                head_ra = r_item.node_a;
                if (r_used > (LINK_W+1)'(LINKS-2)) n_out.status = ST_FULL;
            end
            S_ADD2: begin
                adj_we = 1'b1; adj_wa = r_used[LINK_W-1:0];
                adj_wd = {head_rd, r_item.node_b};
                head_we = 1'b1; head_wa = r_item.node_a;
                head_wd = {1'b1, r_used[LINK_W-1:0]};
                head_ra = r_item.node_b;
            end
            S_ADD3: begin
                // when a equals b the head of b read in S_ADD2 misses a's write; use the new head
                adj_we = 1'b1; adj_wa = LINK_W'(r_used + 1'b1);
                adj_wd = {(r_item.node_a == r_item.node_b)
                          ? {1'b1, r_used[LINK_W-1:0]} : head_rd, r_item.node_a};
                head_we = 1'b1; head_wa = r_item.node_b;
                head_wd = {1'b1, LINK_W'(r_used + 1'b1)};
            end
            S_VCLR: begin
                inf_we = 1'b1; inf_wa = r_cnt[NODE_W-1:0];
            end
            S_ROOT: inf_ra = r_cnt[NODE_W-1:0];
            S_ROOT_RD: head_ra = r_cnt[NODE_W-1:0];
            S_ENTER: begin
                // head_rd holds the head of the node being entered
                inf_we = 1'b1; inf_wa = r_child;
                inf_wd = {1'b1, r_clock, r_clock};
                stk_we = 1'b1; stk_wa = r_depth[NODE_W-1:0];
                stk_wd = {r_child, r_fn, r_fhp, head_rd};
            end
            S_TOP_RD: inf_ra = stk_rd[FRM_W-1 -: NODE_W];
            S_NB_RD: begin
                inf_ra = adj_nb;
                head_ra = adj_nb;
                stk_we = 1'b1; stk_wa = top_idx;
                stk_wd = {r_fn, r_fp, r_fhp, adj_next};
            end
            S_NB_CHK: begin
                // keep the child's head on the read port for a descent
                head_ra = r_child;
                if (!nb_skip && inf_vis) begin
                    inf_we = 1'b1; inf_wa = r_fn;
                    inf_wd = {1'b1, r_discn, (inf_disc < r_lown) ? inf_disc : r_lown};
                end
            end
            S_POP: stk_ra = NODE_W'(r_depth - 2'd2);
            S_POP_RD: inf_ra = stk_rd[FRM_W-1 -: NODE_W];
            S_POP_UPD: begin
                if (r_found <= (NODE_W+1)'(NODES-1) && r_lown > inf_disc) begin
                    br_we = 1'b1; br_wa = r_found[NODE_W-1:0];
                    br_wd = (r_fn < r_popn) ? {r_fn, r_popn} : {r_popn, r_fn};
                end
                if (r_lown < inf_low) begin
                    inf_we = 1'b1; inf_wa = r_fn;
                    inf_wd = {1'b1, inf_disc, r_lown};
                end
            end
            S_SORT_I: br_ra = r_si[NODE_W-1:0];
            S_SORT_RD: br_ra = NODE_W'(r_sj - 1'b1);
            S_SORT_CMP: begin
                br_ra = NODE_W'(r_sj - 2'd2);
                if (sort_move) begin
                    br_we = 1'b1; br_wa = r_sj[NODE_W-1:0]; br_wd = br_rd;
                end
            end
            S_SORT_PUT: begin
                br_we = 1'b1; br_wa = r_sj[NODE_W-1:0]; br_wd = r_key;
            end
            S_READ: br_ra = r_item.bridge_index;
            S_READ_RD: begin
                n_out.status = ST_OK;
                n_out.end_low = br_rd[2*NODE_W-1:NODE_W];
                n_out.end_high = br_rd[NODE_W-1:0];
                if ({1'b0, r_item.bridge_index} >= r_found) begin
                    n_out.status = ST_RANGE; n_out.end_low = '0; n_out.end_high = '0;
                end
            end
            S_OUT: begin
                if (r_item.op == OP_RUN) n_out.bridge_count = r_found[NODE_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_node_count <= '0;
            r_ovalid <= 1'b0;
            r_used <= '0;
            r_cnt <= '0;
            r_depth <= '0;
            r_clock <= '0;
            r_found <= '0;
            r_count <= '0;
            r_item <= '0;
            r_out <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_node_count <= i_cfg_data;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (take) begin
                r_item <= i_in;
                r_cnt <= '0;
                r_found <= (t_op'(i_in.op) == OP_RUN) ? '0 : r_found;
                r_out <= '{status: ST_OK, bridge_count: r_count,
                           end_low: '0, end_high: '0};
            end else begin
                r_out <= n_out;
            end
            case (r_state)
                S_INIT: r_cnt <= r_cnt + 1'b1;
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (n_state == S_OUT) r_used <= '0;
                end
                S_ADD3: r_used <= r_used + 2'd2;
                S_VCLR: r_cnt <= (n_state == S_ROOT) ? '0 : r_cnt + 1'b1;
                S_ROOT: begin
                    r_child <= r_cnt[NODE_W-1:0];
                    r_fhp <= 1'b0; r_fn <= '0;
                    r_clock <= '0; r_depth <= '0;
                end
                S_ROOT_RD: if (inf_vis) r_cnt <= r_cnt + 1'b1;
                S_ENTER: begin
                    r_clock <= r_clock + 1'b1;
                    r_depth <= r_depth + 1'b1;
                end
                S_TOP: if (r_depth == '0) r_cnt <= r_cnt + 1'b1;
                S_TOP_RD: begin
                    r_fn <= stk_rd[FRM_W-1 -: NODE_W];
                    r_fp <= stk_rd[FRM_W-NODE_W-1 -: NODE_W];
                    r_fhp <= stk_rd[HEAD_W];
                    r_flink <= stk_rd[HEAD_W-1:0];
                end
                S_NB: begin
                    // fresh record of the current node
                    r_lown <= inf_low;
                    r_discn <= inf_disc;
                end
                S_NB_RD: r_child <= adj_nb;
                S_NB_CHK: begin
                    // enter child: frame parent is current node
                    if (!nb_skip && !inf_vis) r_fhp <= 1'b1;
                end
                S_POP: begin
                    r_depth <= r_depth - 1'b1;
                    r_popn <= r_fn;
                end
                S_POP_RD: r_fn <= stk_rd[FRM_W-1 -: NODE_W];
                S_POP_UPD: begin
                    if (r_found <= (NODE_W+1)'(NODES-1) && r_lown > inf_disc)
                        r_found <= r_found + 1'b1;
                end
                S_SORT_I: r_sj <= r_si;
                S_SORT_RD: r_key <= br_rd;
                S_SORT_CMP: begin
                    if (sort_move) begin
                        r_sj <= r_sj - 1'b1;
                    end else begin
                        r_si <= r_si + 1'b1;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    if (r_item.op == OP_RUN) r_count <= r_found[NODE_W-1:0];
                end
                default: ;
            endcase
            if (r_state == S_IDLE && take && t_op'(i_in.op) == OP_RUN) r_si <= '0;
        end
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;
endmodule
